// File: hw/rtl/lattice_boltzmann_diffusion_1d_top_assert.svh
// Assertion macros for the lattice solver top module.
`ifndef LATTICE_BOLTZMANN_DIFFUSION_1D_TOP_ASSERT_SVH
`define LATTICE_BOLTZMANN_DIFFUSION_1D_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LBD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define LBD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LBD_ASSERT(name, clk, rst, prop, msg)

`define LBD_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: hw/rtl/lbd_pkg.sv
package lbd_pkg;

  typedef logic signed [19:0] q_t;

  localparam q_t Q_MAX = 20'sh7FFFF;
  localparam q_t Q_MIN = 20'sh80000;

  localparam int RELAX_W = 17;
  localparam int WALL_W  = 18;

  localparam logic [RELAX_W-1:0]       RELAX_RESET = 17'd87381;
  localparam logic signed [WALL_W-1:0] WALL_RESET  = 18'sd65536;

  // Configuration register indexes.
  localparam logic REG_RELAX = 1'b0;
  localparam logic REG_WALL  = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // One memory word holds everything stored for a node.
  typedef struct packed {
    q_t rho;
    q_t lm;
    q_t rm;
  } node_word_t;

  localparam int WORD_W = $bits(node_word_t);

  // Node position flags issued with each read of a time step.
  typedef struct packed {
    logic valid;
    logic first;
    logic second;
    logic last;
  } issue_t;

  // Collision result for one node.
  typedef struct packed {
    logic valid;
    logic first;
    logic second;
    logic last;
    q_t   rho;
    q_t   rp;
    q_t   lp;
  } coll_t;

  function automatic q_t sat_q(input logic signed [23:0] v);
    q_t r;
    if (v > 24'sd524287) begin
      r = Q_MAX;
    end else if (v < -24'sd524288) begin
      r = Q_MIN;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/lbd_ifs.sv
interface lbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] step_count;
  logic [6:0]  node_index;

  modport source (output valid, output cmd, output step_count, output node_index, input ready);
  modport sink (input valid, input cmd, input step_count, input node_index, output ready);
endinterface

interface lbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] density;
  logic               done_res;

  modport source (output valid, output density, output done_res, input ready);
  modport sink (input valid, input density, input done_res, output ready);
endinterface

// File: hw/rtl/lattice_boltzmann_diffusion_1d_top.sv
// D1Q2 lattice Boltzmann diffusion solver over a row of NODES nodes.
// Commands arrive as words on in_ch (cmd, step_count, node_index); each
// command returns one word on out_ch (density, done_res). relax_rate and
// wall_value are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block does not enforce it. Per-node state
// (both distributions and the density) lives in one synchronous RAM; each
// time step walks the nodes in order through a five-stage collision
// pipeline and writes the streamed values back.
// Before the result is loaded, clear zeroes the RAM one row per cycle;
// run makes one read port access per node per step, then waits for the
// pipeline drain and the right-edge write, and zero steps returns at once;
// read loads the result in the cycle after acceptance; an unused command
// returns at once.
// After reset the RAM is swept to zero before the first command is
// accepted. One command is in flight at a time; a result waits
// in the output register while out_ch.ready is low, and in_ch.ready stays
// low until that register is free or being emptied.
`include "lattice_boltzmann_diffusion_1d_top_assert.svh"

module lattice_boltzmann_diffusion_1d_top #(
  parameter int NODES = 128
) (
  input  logic              clk,
  input  logic              rst,
  lbd_in_if.sink            in_ch,
  lbd_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [17:0]       cfg_data
);

  localparam int AW = $clog2(NODES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RUN, S_DRAIN, S_READ} state_t;

  state_t state;

  logic [lbd_pkg::RELAX_W-1:0]       relax_rate;
  logic signed [lbd_pkg::WALL_W-1:0] wall_value;

  logic [AW-1:0] clr_idx, rd_idx;
  logic          clr_cmd;
  logic          read_oob;
  logic [15:0]   steps_left;

  logic               out_valid;
  lbd_pkg::q_t        out_density;
  logic               out_done;

  logic                accept;
  lbd_pkg::issue_t     issue;
  lbd_pkg::coll_t      coll;
  lbd_pkg::node_word_t rdata, ram_wdata, st_wdata;
  logic                ram_we, st_we, step_done;
  logic [AW-1:0]       ram_waddr, ram_raddr, st_waddr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= lbd_pkg::RELAX_RESET;
      wall_value <= lbd_pkg::WALL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbd_pkg::REG_RELAX: relax_rate <= cfg_data[lbd_pkg::RELAX_W-1:0];
        lbd_pkg::REG_WALL:  wall_value <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_ch.ready     = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.density  = out_density;
  assign out_ch.done_res = out_done;

  always_comb begin
    issue.valid  = (state == S_RUN);
    issue.first  = (rd_idx == '0);
    issue.second = (rd_idx == AW'(1));
    issue.last   = (rd_idx == LAST_IDX);
    ram_raddr    = (state == S_RUN) ? rd_idx : AW'(in_ch.node_index);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = st_we;
      ram_waddr = st_waddr;
      ram_wdata = st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      clr_cmd    <= 1'b0;
      rd_idx     <= '0;
      steps_left <= '0;
      read_oob   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // An accepted command decides the output register itself.
      if (out_valid && out_ch.ready && !accept) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == LAST_IDX) begin
            clr_idx <= '0;
            state   <= S_IDLE;
            if (clr_cmd) begin
              clr_cmd     <= 1'b0;
              out_valid   <= 1'b1;
              out_density <= '0;
              out_done    <= 1'b1;
            end
          end else begin
            clr_idx <= clr_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_ch.cmd)
              lbd_pkg::CMD_CLEAR: begin
                out_valid <= 1'b0;
                clr_cmd   <= 1'b1;
                state     <= S_CLEAR;
              end
              lbd_pkg::CMD_RUN: begin
                if (in_ch.step_count == '0) begin
                  out_valid   <= 1'b1;
                  out_density <= '0;
                  out_done    <= 1'b1;
                end else begin
                  out_valid  <= 1'b0;
                  steps_left <= in_ch.step_count;
                  rd_idx     <= '0;
                  state      <= S_RUN;
                end
              end
              lbd_pkg::CMD_READ: begin
                out_valid <= 1'b0;
                read_oob  <= !(32'(in_ch.node_index) < NODES);
                state     <= S_READ;
              end
              default: begin
                out_valid   <= 1'b1;
                out_density <= '0;
                out_done    <= 1'b0;
              end
            endcase
          end
        end
        S_RUN: begin
          if (rd_idx == LAST_IDX) begin
            rd_idx <= '0;
            state  <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + AW'(1);
          end
        end
        S_DRAIN: begin
          // The next step may only start once every word of this one is back.
          if (step_done) begin
            if (steps_left == 16'd1) begin
              out_valid   <= 1'b1;
              out_density <= '0;
              out_done    <= 1'b1;
              state       <= S_IDLE;
            end else begin
              steps_left <= steps_left - 16'd1;
              state      <= S_RUN;
            end
          end
        end
        S_READ: begin
          out_valid   <= 1'b1;
          out_density <= read_oob ? '0 : rdata.rho;
          out_done    <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lbd_ram #(
    .WIDTH(lbd_pkg::WORD_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  lbd_collide u_collide (
    .clk       (clk),
    .rst       (rst),
    .relax_rate(relax_rate),
    .issue     (issue),
    .rdata     (rdata),
    .coll      (coll)
  );

  lbd_stream #(
    .NODES(NODES)
  ) u_stream (
    .clk       (clk),
    .rst       (rst),
    .wall_value(wall_value),
    .coll      (coll),
    .we        (st_we),
    .waddr     (st_waddr),
    .wdata     (st_wdata),
    .step_done (step_done)
  );

  `LBD_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> state == S_CLEAR, "no clear after reset")
  `LBD_ASSERT(a_wr_busy, clk, rst, ram_we |-> state != S_IDLE && state != S_READ, "idle write")
  `LBD_ASSERT(a_coll_in_run, clk, rst, coll.valid |-> state == S_RUN || state == S_DRAIN, "stray word")
  `LBD_ASSERT(a_tail_follows, clk, rst, coll.valid && coll.last |=> step_done, "edge write missing")

endmodule

// File: hw/rtl/lbd_ram.sv
module lbd_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lbd_collide.sv
module lbd_collide (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lbd_pkg::RELAX_W-1:0]        relax_rate,
  input  lbd_pkg::issue_t                    issue,
  input  lbd_pkg::node_word_t                rdata,
  output lbd_pkg::coll_t                     coll
);

  // Stage 0 lines the flags up with the memory read data.
  lbd_pkg::issue_t ctl0, ctl1, ctl2, ctl3;

  lbd_pkg::q_t rm1, lm1, rho1;
  lbd_pkg::q_t rm2, lm2, rho2;
  lbd_pkg::q_t rm3, lm3, rho3;
  logic signed [20:0] dr2, dl2;
  logic signed [38:0] pr3, pl3;

  lbd_pkg::q_t        eq;
  logic signed [20:0] dr, dl;
  logic signed [17:0] omega;
  logic signed [38:0] pr, pl;
  logic signed [38:0] tr, tl;

  always_comb begin
    eq    = rho1 >>> 1;
    dr    = 21'(eq) - 21'(rm1);
    dl    = 21'(eq) - 21'(lm1);
    omega = $signed({1'b0, relax_rate});
    pr    = 39'(omega) * 39'(dr2);
    pl    = 39'(omega) * 39'(dl2);
    // Round half up, then floor by the Q16 scale.
    tr    = (pr3 + 39'sd32768) >>> 16;
    tl    = (pl3 + 39'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0       <= '0;
      ctl1       <= '0;
      ctl2       <= '0;
      ctl3       <= '0;
      coll.valid <= 1'b0;
    end else begin
      ctl0       <= issue;
      ctl1       <= ctl0;
      ctl2       <= ctl1;
      ctl3       <= ctl2;
      coll.valid <= ctl3.valid;
    end
    rm1  <= rdata.rm;
    lm1  <= rdata.lm;
    rho1 <= lbd_pkg::sat_q(24'(rdata.rm) + 24'(rdata.lm));

    rm2  <= rm1;
    lm2  <= lm1;
    rho2 <= rho1;
    dr2  <= dr;
    dl2  <= dl;

    rm3  <= rm2;
    lm3  <= lm2;
    rho3 <= rho2;
    pr3  <= pr;
    pl3  <= pl;

    coll.first  <= ctl3.first;
    coll.second <= ctl3.second;
    coll.last   <= ctl3.last;
    coll.rho    <= rho3;
    coll.rp     <= lbd_pkg::sat_q(24'(rm3) + 24'($signed(tr[22:0])));
    coll.lp     <= lbd_pkg::sat_q(24'(lm3) + 24'($signed(tl[22:0])));
  end

endmodule

// File: hw/rtl/lbd_stream.sv
module lbd_stream #(
  parameter int NODES = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [lbd_pkg::WALL_W-1:0]  wall_value,
  input  lbd_pkg::coll_t                     coll,
  output logic                               we,
  output logic [$clog2(NODES)-1:0]           waddr,
  output lbd_pkg::node_word_t                wdata,
  output logic                               step_done
);

  localparam int AW = $clog2(NODES);

  // A node's word is written once the node to its right has collided,
  // because its new left mover comes from there.
  lbd_pkg::q_t prev_rp, prev2_rp, prev_lp, prev_rho;
  logic [AW-1:0]       wcnt;
  logic                tail_pend;
  lbd_pkg::node_word_t tail_word;

  lbd_pkg::q_t new_r, new_l;

  always_comb begin
    new_l = coll.last ? prev_lp : coll.lp;
    if (coll.second) begin
      new_r = lbd_pkg::sat_q(24'(wall_value) - 24'(coll.lp));
    end else begin
      new_r = prev2_rp;
    end
    we        = tail_pend || (coll.valid && !coll.first);
    waddr     = wcnt;
    wdata     = tail_pend ? tail_word : '{rho: prev_rho, lm: new_l, rm: new_r};
    step_done = tail_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pend <= 1'b0;
      wcnt      <= '0;
    end else begin
      tail_pend <= coll.valid && coll.last;
      if (coll.valid && coll.first) begin
        wcnt <= '0;
      end else if (we) begin
        wcnt <= wcnt + AW'(1);
      end
    end
    if (coll.valid) begin
      prev2_rp <= prev_rp;
      prev_rp  <= coll.rp;
      prev_lp  <= coll.lp;
      prev_rho <= coll.rho;
      if (coll.last) begin
        // The right edge copies its neighbor after streaming.
        tail_word <= '{rho: coll.rho, lm: prev_lp, rm: prev2_rp};
      end
    end
  end

endmodule
